FILE: hdl/escs_pkg.sv
// ----------------------------------------------------------------------------
// escs_pkg
// Types and codes shared by the expiry sorted counted stack and its cells.
// ----------------------------------------------------------------------------
package escs_pkg;

  localparam int CW = 16;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_CONSUME = 2'd1,
    KIND_INSERT  = 2'd2,
    KIND_DRAIN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANOUT = 2'd2,
    STAT_SAT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CMP,
    OP_PUSH,
    OP_POP,
    OP_TRIM,
    OP_INSERT
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CMP,
    S_SCAN,
    S_INS,
    S_CONS,
    S_DRAIN
  } state_t;

  typedef struct packed {
    cell_op_t        op;
    logic [CW-1:0]   cnt;
    logic [CW-1:0]   key;
    logic            merge;
  } cell_cmd_t;

  // ripple flags handed from the top cell toward the bottom
  typedef struct packed {
    logic p;
    logic found;
    logic sat;
  } chain_t;

endpackage

FILE: hdl/expiry_sorted_counted_stack.sv
// ----------------------------------------------------------------------------
// expiry_sorted_counted_stack
// Bounded stack of (count, date) entries kept in a row of cells, top first.
//
// An item (kind, quantity, date) is taken on a rising edge with start high
// and busy low. Each result beat sits on count, entry_date, last, empty_res
// and status for one cycle with strobe high; the receiver cannot stall, so
// results are never held back. The result of an item appears the cycle after
// its work ends, while the block may already take the next item.
// Work per item, from accept to result beat:
//   push    shift the row down and write the top cell (no write when full)
//   insert  compare in every cell, ripple search, write
//   consume pop or trim the top entry until the quantity is met or the
//           stack runs out
//   drain   one beat per entry (one beat when empty), one beat per cycle
// Consume and drain walk the top cell, one entry per cycle; the rest of the
// row shifts along with it.
// Reset empties the stack; entry contents are not cleared and are only
// read below the occupancy.
// ----------------------------------------------------------------------------
module expiry_sorted_counted_stack
  import escs_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int OW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    kind,
  input  logic [CW-1:0] quantity,
  input  logic [CW-1:0] date,
  output logic          strobe,
  output logic [CW-1:0] count,
  output logic [CW-1:0] entry_date,
  output logic          last,
  output logic          empty_res,
  output logic [1:0]    status
);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] rem;
  logic [CW-1:0] date_r;
  logic [OW-1:0] occ;
  logic [OW-1:0] occ_next;
  logic          found;
  logic          sat;
  logic          none;

  cell_cmd_t     cmd;
  logic          occ_inc;
  logic          occ_dec;
  logic          rem_sub;
  logic          fin;
  logic          emit;
  logic [CW-1:0] e_count;
  logic [CW-1:0] e_date;
  logic          e_last;
  logic          e_empty;
  status_t       e_status;
  logic [CW-1:0] need;

  logic [CW-1:0] cnt_w [DEPTH];
  logic [CW-1:0] key_w [DEPTH];
  chain_t        chain_w [DEPTH+1];

  status_t       status_r;

  assign busy     = state != S_IDLE;
  assign status   = status_r;
  assign need     = (cnt_w[0] > CW'(1)) ? cnt_w[0] : CW'(1);
  assign occ_next = occ + OW'(occ_inc) - OW'(occ_dec);

  assign chain_w[0] = '{p: 1'b1, found: 1'b0, sat: 1'b0};

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [CW-1:0] pc;
    logic [CW-1:0] pk;
    logic [CW-1:0] nc;
    logic [CW-1:0] nk;
    if (k == 0) begin : g_top
      assign pc = rem;
      assign pk = date_r;
    end else begin : g_mid
      assign pc = cnt_w[k-1];
      assign pk = key_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_bot
      assign nc = cnt_w[k];
      assign nk = key_w[k];
    end else begin : g_up
      assign nc = cnt_w[k+1];
      assign nk = key_w[k+1];
    end
    escs_cell #(.DEPTH(DEPTH), .IDX(k)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .occ        (occ),
      .prev_count (pc),
      .prev_key   (pk),
      .next_count (nc),
      .next_key   (nk),
      .chain_in   (chain_w[k]),
      .chain_out  (chain_w[k+1]),
      .count_q    (cnt_w[k]),
      .key_q      (key_w[k])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_PUSH:    state_next = S_PUSH;
            KIND_CONSUME: state_next = S_CONS;
            KIND_INSERT:  state_next = S_CMP;
            KIND_DRAIN:   state_next = S_DRAIN;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_CMP:   state_next = S_SCAN;
      S_SCAN:  state_next = S_INS;
      S_INS:   state_next = S_IDLE;
      S_PUSH:  state_next = S_IDLE;
      S_CONS:  state_next = fin ? S_IDLE : S_CONS;
      S_DRAIN: state_next = fin ? S_IDLE : S_DRAIN;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '{op: OP_IDLE, cnt: rem, key: date_r, merge: 1'b0};
    occ_inc   = 1'b0;
    occ_dec   = 1'b0;
    rem_sub   = 1'b0;
    fin       = 1'b0;
    e_count   = '0;
    e_date    = '0;
    e_last    = 1'b1;
    e_status  = STAT_OK;
    case (state)
      S_PUSH: begin
        fin = 1'b1;
        if (occ == OW'(DEPTH)) begin
          e_status = STAT_FULL;
        end else begin
          cmd.op  = OP_PUSH;
          occ_inc = 1'b1;
        end
      end
      S_CMP: begin
        cmd.op = OP_CMP;
      end
      S_INS: begin
        fin = 1'b1;
        if (found) begin
          cmd.op    = OP_INSERT;
          cmd.merge = 1'b1;
          e_status  = sat ? STAT_SAT : STAT_OK;
        end else if (none || occ == OW'(DEPTH)) begin
          e_status = STAT_FULL;
        end else begin
          cmd.op  = OP_INSERT;
          occ_inc = 1'b1;
        end
      end
      S_CONS: begin
        if (rem == '0) begin
          fin = 1'b1;
        end else if (occ == '0) begin
          fin      = 1'b1;
          e_status = STAT_RANOUT;
        end else if (rem >= need) begin
          cmd.op  = OP_POP;
          occ_dec = 1'b1;
          rem_sub = 1'b1;
        end else begin
          cmd.op  = OP_TRIM;
          cmd.cnt = cnt_w[0] - rem;
          fin     = 1'b1;
        end
      end
      S_DRAIN: begin
        if (occ == '0) begin
          fin = 1'b1;
        end else begin
          cmd.op  = OP_POP;
          occ_dec = 1'b1;
          e_count = cnt_w[0];
          e_date  = key_w[0];
          e_last  = occ == OW'(1);
          fin     = occ == OW'(1);
        end
      end
      default: begin
      end
    endcase
    emit    = fin || (state == S_DRAIN);
    e_empty = (state == S_DRAIN) ? (occ == '0) : (occ_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      strobe <= 1'b0;
      found  <= 1'b0;
      sat    <= 1'b0;
      none   <= 1'b0;
    end else begin
      state  <= state_next;
      occ    <= occ_next;
      strobe <= emit;
      if (state == S_SCAN) begin
        found <= chain_w[DEPTH].found;
        sat   <= chain_w[DEPTH].sat;
        none  <= chain_w[DEPTH].p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      rem    <= quantity;
      date_r <= date;
    end else if (rem_sub) begin
      rem <= rem - need;
    end
    if (emit) begin
      count      <= e_count;
      entry_date <= e_date;
      last       <= e_last;
      empty_res  <= e_empty;
      status_r   <= e_status;
    end
  end

endmodule

FILE: hdl/escs_cell.sv
// ----------------------------------------------------------------------------
// escs_cell
// One stack slot: holds a (count, date) entry at a fixed depth from the top,
// shifts with its neighbors on push and pop, and takes part in the insert
// search through a ripple of flags.
// ----------------------------------------------------------------------------
module escs_cell
  import escs_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  localparam int OW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_cmd_t     cmd,
  input  logic [OW-1:0] occ,
  input  logic [CW-1:0] prev_count,
  input  logic [CW-1:0] prev_key,
  input  logic [CW-1:0] next_count,
  input  logic [CW-1:0] next_key,
  input  chain_t        chain_in,
  output chain_t        chain_out,
  output logic [CW-1:0] count_q,
  output logic [CW-1:0] key_q
);

  logic [CW-1:0] cnt;
  logic [CW-1:0] key;
  logic          stop;
  logic          eq;
  logic          ovf;
  logic          pr;
  logic          mt;
  logic          valid;
  logic [CW:0]   sum;
  logic          hit;

  assign valid   = OW'(IDX) < occ;
  assign sum     = {1'b0, cnt} + {1'b0, cmd.cnt};
  assign hit     = chain_in.p & stop & eq;
  assign count_q = cnt;
  assign key_q   = key;

  assign chain_out.p     = chain_in.p & ~stop;
  assign chain_out.found = chain_in.found | hit;
  assign chain_out.sat   = chain_in.sat | (hit & ovf);

  always_ff @(posedge clk) begin
    if (rst) begin
      stop <= 1'b0;
      eq   <= 1'b0;
      ovf  <= 1'b0;
      pr   <= 1'b0;
      mt   <= 1'b0;
    end else begin
      pr <= chain_in.p;
      mt <= chain_in.p & stop;
      if (cmd.op == OP_CMP) begin
        stop <= ~valid | (key >= cmd.key);
        eq   <= valid & (key == cmd.key);
        ovf  <= sum[CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PUSH: begin
        cnt <= prev_count;
        key <= prev_key;
      end
      OP_POP: begin
        cnt <= next_count;
        key <= next_key;
      end
      OP_TRIM: begin
        if (IDX == 0) begin
          cnt <= cmd.cnt;
        end
      end
      OP_INSERT: begin
        if (mt) begin
          if (cmd.merge) begin
            cnt <= ovf ? {CW{1'b1}} : sum[CW-1:0];
          end else begin
            cnt <= cmd.cnt;
            key <= cmd.key;
          end
        end else if (!pr && !cmd.merge) begin
          cnt <= prev_count;
          key <= prev_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: dv/escs_checker.sv
// ----------------------------------------------------------------------------
// escs_checker
// Watches the item and result channels of the expiry sorted counted stack,
// keeps its own copy of the stack contents, predicts the result beats of
// every accepted item and compares each result beat field by field with the
// oldest prediction. Hands the number of failures and the number of beats
// still due to the testbench top.
// ----------------------------------------------------------------------------
module escs_checker
  import escs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  logic [1:0]    kind,
  input  logic [CW-1:0] quantity,
  input  logic [CW-1:0] date,
  input  logic          strobe,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] entry_date,
  input  logic          last,
  input  logic          empty_res,
  input  logic [1:0]    status,
  output int            errors,
  output int            pending
);

  typedef struct packed {
    logic [CW-1:0] cnt;
    logic [CW-1:0] key;
    logic          lst;
    logic          emp;
    status_t       st;
  } beat_t;

  beat_t         due_beats[$];
  logic [CW-1:0] shelf_cnt [DEPTH];
  logic [CW-1:0] shelf_key [DEPTH];
  int            shelf_fill = 0;
  int            fail_n = 0;
  int            due_n = 0;

  assign errors  = fail_n;
  assign pending = due_n;

  function automatic beat_t mk_beat(logic [CW-1:0] c, logic [CW-1:0] k, logic l,
                                    logic e, status_t s);
    beat_t b;
    b.cnt = c;
    b.key = k;
    b.lst = l;
    b.emp = e;
    b.st  = s;
    return b;
  endfunction

  task automatic flag(string what, int unsigned got, int unsigned want);
    if (fail_n < 200)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_n++;
  endtask

  task automatic take_units(input logic [CW-1:0] q, output status_t st);
    int unsigned left;
    int unsigned need;
    left = 32'(q);
    st   = STAT_OK;
    while (left > 0) begin
      if (shelf_fill == 0) begin
        st   = STAT_RANOUT;
        left = 0;
      end else begin
        need = (shelf_cnt[shelf_fill-1] > CW'(1)) ? 32'(shelf_cnt[shelf_fill-1]) : 32'd1;
        if (left >= need) begin
          shelf_fill--;
          left -= need;
        end else begin
          shelf_cnt[shelf_fill-1] = shelf_cnt[shelf_fill-1] - left[CW-1:0];
          left = 0;
        end
      end
    end
  endtask

  task automatic sort_in(input logic [CW-1:0] q, input logic [CW-1:0] d,
                         output status_t st);
    int          pos;
    int unsigned sum;
    pos = shelf_fill;
    while (pos > 0 && shelf_key[pos-1] < d) pos--;
    if (pos > 0 && shelf_key[pos-1] == d) begin
      sum = 32'(shelf_cnt[pos-1]) + 32'(q);
      if (sum > 32'h0000_FFFF) begin
        shelf_cnt[pos-1] = '1;
        st = STAT_SAT;
      end else begin
        shelf_cnt[pos-1] = sum[CW-1:0];
        st = STAT_OK;
      end
    end else if (shelf_fill >= DEPTH) begin
      st = STAT_FULL;
    end else begin
      for (int i = shelf_fill; i > pos; i--) begin
        shelf_cnt[i] = shelf_cnt[i-1];
        shelf_key[i] = shelf_key[i-1];
      end
      shelf_cnt[pos] = q;
      shelf_key[pos] = d;
      shelf_fill++;
      st = STAT_OK;
    end
  endtask

  task automatic apply_item(kind_t k, logic [CW-1:0] q, logic [CW-1:0] d);
    status_t st;
    st = STAT_OK;
    case (k)
      KIND_DRAIN: begin
        if (shelf_fill == 0) begin
          due_beats.push_back(mk_beat('0, '0, 1'b1, 1'b1, STAT_OK));
        end else begin
          for (int i = shelf_fill; i > 0; i--)
            due_beats.push_back(mk_beat(shelf_cnt[i-1], shelf_key[i-1], i == 1, 1'b0,
                                        STAT_OK));
          shelf_fill = 0;
        end
      end
      KIND_PUSH: begin
        if (shelf_fill >= DEPTH) begin
          st = STAT_FULL;
        end else begin
          shelf_cnt[shelf_fill] = q;
          shelf_key[shelf_fill] = d;
          shelf_fill++;
        end
      end
      KIND_CONSUME: take_units(q, st);
      default: sort_in(q, d, st);
    endcase
    if (k != KIND_DRAIN)
      due_beats.push_back(mk_beat('0, '0, 1'b1, shelf_fill == 0, st));
  endtask

  always @(posedge clk) begin : watch
    beat_t want;
    if (rst) begin
      shelf_fill = 0;
      due_beats.delete();
    end else begin
      if (strobe) begin
        if (due_beats.size() == 0) begin
          flag("beat with nothing due, count", 32'(count), 0);
        end else begin
          want = due_beats.pop_front();
          if (count !== want.cnt)
            flag("count", 32'(count), 32'(want.cnt));
          if (entry_date !== want.key)
            flag("entry_date", 32'(entry_date), 32'(want.key));
          if (last !== want.lst)
            flag("last", 32'(last), 32'(want.lst));
          if (empty_res !== want.emp)
            flag("empty_res", 32'(empty_res), 32'(want.emp));
          if (status !== 2'(want.st))
            flag("status", 32'(status), 32'(want.st));
        end
      end
      if (start && !busy)
        apply_item(kind_t'(kind), quantity, date);
    end
    due_n = due_beats.size();
  end

endmodule

FILE: dv/tb_expiry_sorted_counted_stack.sv
// ----------------------------------------------------------------------------
// tb_expiry_sorted_counted_stack
// Drives the expiry sorted counted stack with a directed run through empty,
// full, saturating, zero and run-out cases, then with random pushes,
// inserts, consumes and drains with random idle gaps. A checker beside the
// block predicts and compares every result beat; the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_expiry_sorted_counted_stack;
  import escs_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 200000;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  logic [1:0]    kind;
  logic [CW-1:0] quantity;
  logic [CW-1:0] date;
  logic          strobe;
  logic [CW-1:0] count;
  logic [CW-1:0] entry_date;
  logic          last;
  logic          empty_res;
  logic [1:0]    status;
  int            errors;
  int            pending;
  int            cycles = 0;
  logic          burst;

  expiry_sorted_counted_stack #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .quantity(quantity), .date(date),
    .strobe(strobe), .count(count), .entry_date(entry_date),
    .last(last), .empty_res(empty_res), .status(status)
  );

  escs_checker #(.DEPTH(DEPTH)) u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .quantity(quantity), .date(date),
    .strobe(strobe), .count(count), .entry_date(entry_date),
    .last(last), .empty_res(empty_res), .status(status),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one item: stay idle for the given gap, then hold start until taken
  task automatic send_item(kind_t k, logic [CW-1:0] q, logic [CW-1:0] d, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    kind     <= k;
    quantity <= q;
    date     <= d;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random(int gap);
    kind_t         k;
    logic [CW-1:0] q;
    logic [CW-1:0] d;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      k = KIND_PUSH;
    else if (pick < 60) k = KIND_INSERT;
    else if (pick < 85) k = KIND_CONSUME;
    else                k = KIND_DRAIN;
    pick = $urandom_range(0, 15);
    if (pick == 0)      q = '0;
    else if (pick == 1) q = '1;
    else if (pick < 6)  q = CW'($urandom);
    else                q = CW'($urandom_range(1, 40));
    pick = $urandom_range(0, 9);
    if (pick < 6)       d = CW'($urandom_range(0, 7) * 1000);
    else if (pick == 6) d = '0;
    else if (pick == 7) d = '1;
    else                d = CW'($urandom);
    send_item(k, q, d, gap);
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    kind     = '0;
    quantity = '0;
    date     = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty stack, zero quantities, saturation
    send_item(KIND_DRAIN, CW'($urandom), CW'($urandom), $urandom_range(0, 17));
    send_item(KIND_CONSUME, '1, CW'($urandom), $urandom_range(0, 17));
    send_item(KIND_CONSUME, '0, CW'($urandom), $urandom_range(0, 17));
    send_item(KIND_PUSH, '0, 16'd100, $urandom_range(0, 17));
    send_item(KIND_CONSUME, 16'd1, CW'($urandom), $urandom_range(0, 17));
    send_item(KIND_PUSH, '1, '1, $urandom_range(0, 17));
    send_item(KIND_INSERT, 16'd1, '1, $urandom_range(0, 17));
    send_item(KIND_INSERT, '0, '0, $urandom_range(0, 17));
    // fill up, then hit the full cases
    for (int i = 0; i < DEPTH - 2; i++)
      send_item(KIND_INSERT, CW'($urandom_range(1, 65535)), 16'(100 + 37 * i),
                $urandom_range(0, 17));
    send_item(KIND_PUSH, 16'd7, 16'd9, $urandom_range(0, 17));
    send_item(KIND_INSERT, 16'd7, 16'd50, $urandom_range(0, 17));
    send_item(KIND_INSERT, 16'd5, 16'd100, $urandom_range(0, 17));
    send_item(KIND_CONSUME, 16'd3, CW'($urandom), $urandom_range(0, 17));
    send_item(KIND_DRAIN, CW'($urandom), CW'($urandom), $urandom_range(0, 17));
    wait_drained();

    for (int n = 0; n < 200; n++) begin
      if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n == 100 || $urandom_range(0, 29) == 0) wait_drained();
      send_random(burst ? 0 : $urandom_range(0, 17));
    end

    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
